// ===== rtl/bmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types and constants of the block mean downsampler.
// ----------------------------------------------------------------------------
package bmd_pkg;

  // Running sum and saturating valid count kept for each output column
  localparam int SUM_W = 32;
  localparam int CNT_W = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration port
  localparam int BS_W      = 5;
  localparam int IW_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b1;
  localparam logic [BS_W-1:0] BS_RESET = 5'd1;
  localparam logic [IW_W-1:0] IW_RESET = 13'd4096;

  localparam int OUT_COL_W = 12;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } mem_entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic [SUM_W-1:0] quot;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

endpackage

// ===== rtl/bmd_divider.sv =====
// ----------------------------------------------------------------------------
// bmd_divider
// Unsigned restoring divider, one quotient bit per cycle. A divisor of zero
// or one bypasses the iteration and goes straight to the done state.
// ----------------------------------------------------------------------------
module bmd_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmd_pkg::div_req_t  req_i,
  input  logic               ack_i,
  output bmd_pkg::div_rsp_t  rsp_o
);

  localparam int SW = bmd_pkg::SUM_W;
  localparam int CW = bmd_pkg::CNT_W;
  localparam int IW = $clog2(SW);

  bmd_pkg::div_state_e state_q, state_d;
  logic [IW-1:0] step_q;
  logic [SW-1:0] num_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] div_q;

  logic [CW:0]   trial;
  logic          fits;
  logic [CW:0]   diff;

  assign trial = {rem_q, num_q[SW-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      bmd_pkg::DIV_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.divisor <= CW'(1)) ? bmd_pkg::DIV_DONE : bmd_pkg::DIV_RUN;
        end
      end
      bmd_pkg::DIV_RUN: begin
        if (step_q == IW'(SW - 1)) state_d = bmd_pkg::DIV_DONE;
      end
      bmd_pkg::DIV_DONE: begin
        if (ack_i) state_d = bmd_pkg::DIV_IDLE;
      end
      default: state_d = bmd_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmd_pkg::DIV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == bmd_pkg::DIV_IDLE) step_q <= '0;
      else if (state_q == bmd_pkg::DIV_RUN) step_q <= step_q + IW'(1);
    end
  end

  // Quotient bits shift into num_q as the dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (state_q == bmd_pkg::DIV_IDLE && req_i.start) begin
      num_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (state_q == bmd_pkg::DIV_RUN) begin
      num_q <= {num_q[SW-2:0], fits};
      rem_q <= fits ? diff[CW-1:0] : trial[CW-1:0];
    end
  end

  assign rsp_o.idle = (state_q == bmd_pkg::DIV_IDLE);
  assign rsp_o.done = (state_q == bmd_pkg::DIV_DONE);
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/block_mean_downsampler.sv =====
// ----------------------------------------------------------------------------
// block_mean_downsampler
// Box downsampler: mean of the valid pixels of each block_size square block.
// Takes one pixel per cycle while in_stall_o is low; per-column sums and counts
// live in one RAM with a registered read, read on accept and written back when
// stage 1 advances. A block end starts the 32-step shared divider, which a block
// holding at most one valid pixel bypasses. A block end that finds the divider
// busy holds the input until the divider frees. Reset clears positions and sets
// block_size 1, image_width 4096; the RAM is not cleared. A block_size write
// recomputes the column position with the input held.
// ----------------------------------------------------------------------------
module block_mean_downsampler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_BLOCK  = 16,
  parameter int PIXEL_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bmd_pkg::CFG_W-1:0]           cfg_wdata_i,
  // pixel channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [PIXEL_BITS-1:0]        pixel_value_i,
  input  logic                                pixel_valid_i,
  input  logic                                frame_start_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [PIXEL_BITS-1:0]        block_mean_o,
  output logic                                mean_valid_o,
  output logic [bmd_pkg::OUT_COL_W-1:0]       out_column_o,
  output logic                                row_end_o
);

  localparam int SW   = bmd_pkg::SUM_W;
  localparam int CW   = bmd_pkg::CNT_W;
  localparam int PCW  = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int BW   = $clog2(MAX_BLOCK + 1);
  localparam int RW   = $clog2(MAX_BLOCK);
  localparam int EW   = WW + 2;
  localparam int WCW  = (WW > bmd_pkg::IW_W) ? WW : bmd_pkg::IW_W;
  localparam int BCW  = (BW > bmd_pkg::BS_W) ? BW : bmd_pkg::BS_W;
  localparam int OCW  = bmd_pkg::OUT_COL_W;
  localparam logic [SW-1:0] HALF = SW'(1) << (PIXEL_BITS - 1);
  localparam logic [PIXEL_BITS-1:0] MEAN_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};
  localparam logic [PIXEL_BITS-1:0] MEAN_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bmd_pkg::BS_W-1:0] bs_q;
  logic [bmd_pkg::IW_W-1:0] iw_q;
  logic                     recalc_pend_q;

  logic [BCW-1:0] bs_x;
  logic [WCW-1:0] iw_x;
  logic [BW-1:0]  b_eff;
  logic [WW-1:0]  w_eff;

  assign bs_x = BCW'(bs_q);
  assign iw_x = WCW'(iw_q);

  always_comb begin
    if (bs_x == '0) b_eff = BW'(1);
    else if (bs_x > BCW'(MAX_BLOCK)) b_eff = BW'(MAX_BLOCK);
    else b_eff = BW'(bs_x);
    if (iw_x == '0) w_eff = WW'(1);
    else if (iw_x > WCW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(iw_x);
  end

  // --------------------------------------------------------------------------
  // Position tracking (stage 0)
  // --------------------------------------------------------------------------
  logic [PCW-1:0] pc_q, oc_q, base_q;
  logic [RW-1:0]  rem_q, rib_q, cib_q;

  logic [PCW-1:0] pc0, oc0, base0, pc_n, oc_n, base_n;
  logic [RW-1:0]  rem0, rib0, cib0, rem_n, rib_n, cib_n;
  logic [BW-1:0]  cib_inc, rib_inc, rem_inc;
  logic [WW-1:0]  pc_inc;
  logic [EW-1:0]  blk_hi;
  logic           active, blk_end, fresh, last_blk;

  bmd_pkg::div_rsp_t div_rsp;
  bmd_pkg::div_req_t div_req;
  logic              div_ack;
  logic              job_recalc_q;
  logic              recalc_done;

  logic accept;
  logic s1_vld_q, s1_adv;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    if (frame_start_i) begin
      pc0   = '0;
      oc0   = '0;
      base0 = '0;
      rem0  = '0;
      rib0  = '0;
      cib0  = '0;
    end else begin
      pc0   = pc_q;
      oc0   = oc_q;
      base0 = base_q;
      rem0  = rem_q;
      rib0  = rib_q;
      cib0  = cib_q;
    end

    blk_hi   = EW'(base0) + EW'(b_eff);
    active   = (WW'(pc0) < w_eff) && (blk_hi <= EW'(w_eff));
    last_blk = (blk_hi + EW'(b_eff)) > EW'(w_eff);
    cib_inc  = BW'(cib0) + BW'(1);
    rib_inc  = BW'(rib0) + BW'(1);
    rem_inc  = BW'(rem0) + BW'(1);
    blk_end  = (rib_inc >= b_eff) && (cib_inc >= b_eff);
    fresh    = (rib0 == '0) && (cib0 == '0);

    cib_n = (cib_inc >= b_eff) ? '0 : RW'(cib_inc);
    if (rem_inc >= b_eff) begin
      rem_n  = '0;
      oc_n   = oc0 + PCW'(1);
      base_n = PCW'(blk_hi);
    end else begin
      rem_n  = RW'(rem_inc);
      oc_n   = oc0;
      base_n = base0;
    end
    pc_inc = WW'(pc0) + WW'(1);
    rib_n  = rib0;
    pc_n   = PCW'(pc_inc);
    if (pc_inc >= w_eff) begin
      pc_n   = '0;
      cib_n  = '0;
      rem_n  = '0;
      oc_n   = '0;
      base_n = '0;
      rib_n  = (rib_inc >= b_eff) ? '0 : RW'(rib_inc);
    end
  end

  assign recalc_done = div_rsp.done && job_recalc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q          <= bmd_pkg::BS_RESET;
      iw_q          <= bmd_pkg::IW_RESET;
      recalc_pend_q <= 1'b0;
      pc_q          <= '0;
      oc_q          <= '0;
      base_q        <= '0;
      rem_q         <= '0;
      rib_q         <= '0;
      cib_q         <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == bmd_pkg::REG_BLOCK_SIZE) begin
        bs_q          <= cfg_wdata_i[bmd_pkg::BS_W-1:0];
        recalc_pend_q <= 1'b1;
      end else if (recalc_done) begin
        recalc_pend_q <= 1'b0;
      end
      if (cfg_we_i && cfg_idx_i == bmd_pkg::REG_IMAGE_WIDTH) begin
        iw_q <= cfg_wdata_i[bmd_pkg::IW_W-1:0];
      end
      if (accept) begin
        pc_q   <= pc_n;
        oc_q   <= oc_n;
        base_q <= base_n;
        rem_q  <= rem_n;
        rib_q  <= rib_n;
        cib_q  <= cib_n;
      end else if (recalc_done) begin
        // column / block_size from the divider
        oc_q   <= div_rsp.quot[PCW-1:0];
        rem_q  <= RW'(div_rsp.rem);
        base_q <= pc_q - PCW'(div_rsp.rem);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Column RAM and stage 1 read-modify-write
  // --------------------------------------------------------------------------
  bmd_pkg::mem_entry_t mem [MAX_WIDTH];
  bmd_pkg::mem_entry_t rd_q, old_e, wr_e;

  logic [PCW-1:0]               s1_oc_q;
  logic                         s1_fresh_q, s1_end_q, s1_last_q, s1_pv_q;
  logic signed [PIXEL_BITS-1:0] s1_val_q;

  logic                lw_vld_q;
  logic [PCW-1:0]      lw_addr_q;
  bmd_pkg::mem_entry_t lw_data_q;

  logic [SW-1:0] val_ext;
  logic [SW-1:0] mag;

  assign val_ext = SW'(s1_val_q);

  always_comb begin
    // forward the last write: it may land at the same edge as this read
    old_e = (lw_vld_q && lw_addr_q == s1_oc_q) ? lw_data_q : rd_q;
    if (s1_fresh_q) old_e = '0;
    wr_e.sum = old_e.sum + (s1_pv_q ? val_ext : '0);
    wr_e.cnt = (s1_pv_q && old_e.cnt != bmd_pkg::CNT_MAX) ? old_e.cnt + CW'(1) : old_e.cnt;
    mag      = wr_e.sum[SW-1] ? (~wr_e.sum + SW'(1)) : wr_e.sum;
  end

  assign s1_adv     = s1_vld_q && (!s1_end_q || div_rsp.idle);
  assign in_stall_o = recalc_pend_q || (s1_vld_q && !s1_adv);

  always_ff @(posedge clk_i) begin
    if (s1_adv) mem[s1_oc_q] <= wr_e;
    if (accept) rd_q <= mem[oc0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      lw_vld_q <= 1'b0;
    end else begin
      if (accept) s1_vld_q <= active;
      else if (s1_adv) s1_vld_q <= 1'b0;
      if (s1_adv) lw_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_oc_q    <= oc0;
      s1_fresh_q <= fresh;
      s1_end_q   <= blk_end;
      s1_last_q  <= last_blk;
      s1_pv_q    <= pixel_valid_i;
      s1_val_q   <= pixel_value_i;
    end
    if (s1_adv) begin
      lw_addr_q <= s1_oc_q;
      lw_data_q <= wr_e;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: block means and the column recompute after a block_size write
  // --------------------------------------------------------------------------
  logic start_mean, start_recalc;
  logic out_vld_q, out_load;

  logic           job_neg_q, job_empty_q, job_last_q;
  logic [PCW-1:0] job_oc_q;

  assign start_mean   = s1_vld_q && s1_end_q && div_rsp.idle;
  assign start_recalc = recalc_pend_q && div_rsp.idle && !s1_vld_q && !job_recalc_q;

  always_comb begin
    div_req.start = start_mean || start_recalc;
    if (start_mean) begin
      div_req.dividend = mag;
      div_req.divisor  = wr_e.cnt;
    end else begin
      div_req.dividend = SW'(pc_q);
      div_req.divisor  = CW'(b_eff);
    end
  end

  assign out_load = div_rsp.done && !job_recalc_q && (!out_vld_q || !out_stall_i);
  assign div_ack  = recalc_done || out_load;

  bmd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .ack_i  (div_ack),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_recalc_q <= 1'b0;
    end else begin
      if (start_recalc) job_recalc_q <= 1'b1;
      else if (recalc_done) job_recalc_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_mean) begin
      job_neg_q   <= wr_e.sum[SW-1];
      job_empty_q <= (wr_e.cnt == '0);
      job_oc_q    <= s1_oc_q;
      job_last_q  <= s1_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [SW-1:0]         quot_neg;
  logic [PIXEL_BITS-1:0] mean_d;
  logic [PCW+OCW-1:0]    oc_wide;

  logic [PIXEL_BITS-1:0] mean_q;
  logic                  mvld_q, rend_q;
  logic [OCW-1:0]        ocol_q;

  assign quot_neg = ~div_rsp.quot + SW'(1);
  assign oc_wide  = {{OCW{1'b0}}, job_oc_q};

  always_comb begin
    // truncate toward zero, then saturate to the pixel range
    if (job_empty_q) mean_d = '0;
    else if (job_neg_q) mean_d = (div_rsp.quot > HALF) ? MEAN_MIN : quot_neg[PIXEL_BITS-1:0];
    else mean_d = (div_rsp.quot > HALF - SW'(1)) ? MEAN_MAX : div_rsp.quot[PIXEL_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q <= mean_d;
      mvld_q <= !job_empty_q;
      ocol_q <= oc_wide[OCW-1:0];
      rend_q <= job_last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign block_mean_o = mean_q;
  assign mean_valid_o = mvld_q;
  assign out_column_o = ocol_q;
  assign row_end_o    = rend_q;

endmodule
